[hw/rtl/lbpm_pkg.sv]
// shared types, constants and helper functions for the led bar peak hold meter
package lbpm_pkg;

    // default geometry
    localparam int BARS_DEFAULT = 16;
    localparam int ROWS_DEFAULT = 8;

    // hold lengths in updates
    localparam logic [2:0] FILL_HOLD_LEN = 3'd6;
    localparam logic [3:0] PEAK_HOLD_LEN = 4'd12;

    // peak marker colour
    localparam logic [23:0] PEAK_RGB = 24'hFF_00_00;

    // palette codes
    localparam logic [1:0] FX_TRAFFIC   = 2'd0;
    localparam logic [1:0] FX_BLUE_RED  = 2'd1;
    localparam logic [1:0] FX_GRN_BLUE  = 2'd2;
    localparam logic [1:0] FX_AMBER     = 2'd3;

    // input transaction
    typedef struct packed {
        logic [3:0] bar;
        logic [7:0] level;
    } t_in_item;

    // output transaction, one pixel write
    typedef struct packed {
        logic       tile;
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_out_item;

    // per-bar state word held in memory
    typedef struct packed {
        logic       first;
        logic [2:0] fill;
        logic [2:0] fill_hold;
        logic [2:0] peak;
        logic [3:0] peak_hold;
        logic [7:0] fill_cnt;
        logic [7:0] peak_cnt;
    } t_bar_entry;

    localparam int ENTRY_W = $bits(t_bar_entry);

    // state of a bar never written since reset
    localparam t_bar_entry ENTRY_RESET = '{first: 1'b1, default: '0};

    // request from the update sequencer to the pixel writer
    typedef struct packed {
        logic [3:0] bar;
        logic [2:0] fill;
        logic [2:0] peak;
    } t_draw_cmd;

    // row colour for a palette, as {red, green, blue}
    function automatic logic [23:0] row_colour(input logic [1:0] fx, input logic [2:0] row);
        logic [23:0] rgb;
        rgb = '0;
        case (fx)
            FX_TRAFFIC: begin
                case (row)
                    3'd5, 3'd6: rgb = 24'hFF_80_00;
                    3'd7:       rgb = 24'hFF_00_00;
                    default:    rgb = 24'h00_FF_00;
                endcase
            end
            FX_BLUE_RED: begin
                case (row)
                    3'd0:    rgb = 24'h00_00_FF;
                    3'd1:    rgb = 24'h22_00_DD;
                    3'd2:    rgb = 24'h44_00_BB;
                    3'd3:    rgb = 24'h66_00_99;
                    3'd4:    rgb = 24'h99_00_66;
                    3'd5:    rgb = 24'hBB_00_44;
                    3'd6:    rgb = 24'hDD_00_22;
                    default: rgb = 24'hFF_00_00;
                endcase
            end
            FX_GRN_BLUE: begin
                case (row)
                    3'd0:    rgb = 24'h00_FF_00;
                    3'd1:    rgb = 24'h00_DD_22;
                    3'd2:    rgb = 24'h00_BB_44;
                    3'd3:    rgb = 24'h00_99_66;
                    3'd4:    rgb = 24'h00_77_88;
                    3'd5:    rgb = 24'h00_55_AA;
                    3'd6:    rgb = 24'h00_33_CC;
                    default: rgb = 24'h00_11_EE;
                endcase
            end
            FX_AMBER: begin
                case (row)
                    3'd0:    rgb = 24'hB2_0E_00;
                    3'd1:    rgb = 24'hBD_2B_00;
                    3'd2:    rgb = 24'hC8_48_00;
                    3'd3:    rgb = 24'hD3_64_00;
                    3'd4:    rgb = 24'hDE_81_00;
                    3'd5:    rgb = 24'hE9_9E_00;
                    3'd6:    rgb = 24'hF4_BA_00;
                    default: rgb = 24'hFF_D7_00;
                endcase
            end
            default: rgb = '0;
        endcase
        return rgb;
    endfunction

    // multiple of 3: x times the inverse of 3 mod 256 lands at or below 255/3
    function automatic logic is_mult3(input logic [7:0] x);
        logic [15:0] prod;
        prod = 16'(x) * 16'd171;
        return prod[7:0] <= 8'd85;
    endfunction

    // multiple of 10: even, and half of it a multiple of 5 (inverse of 5 mod 128 is 77)
    function automatic logic is_mult10(input logic [7:0] x);
        logic [13:0] prod;
        prod = 14'(x[7:1]) * 14'd77;
        return !x[0] && (prod[6:0] <= 7'd25);
    endfunction

endpackage

[hw/rtl/lbpm_ram.sv]
// generic single write port ram with registered read
module lbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/lbpm_draw.sv]
// pixel writer: fill rows in palette colour, then the peak row in red
module lbpm_draw (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  lbpm_pkg::t_draw_cmd   i_cmd,
    input  logic [1:0]            i_effect,
    output logic                  o_busy,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output lbpm_pkg::t_out_item   o_out_data
);
    import lbpm_pkg::*;

    logic        r_active, n_active;
    t_draw_cmd   r_cmd;
    logic [2:0]  r_row, n_row;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_data, n_out_data;
    logic        out_free;
    logic        load;
    logic        on_fill;
    logic [2:0]  pix_row;
    logic [23:0] pix_rgb;

    assign out_free = !r_out_valid || !i_out_stall;
    assign load     = r_active && out_free;
    assign on_fill  = r_row < r_cmd.fill;
    assign pix_row  = on_fill ? r_row : r_cmd.peak;
    assign pix_rgb  = on_fill ? row_colour(i_effect, r_row) : PEAK_RGB;

    // next pixel and run sequencing
    always_comb begin
        n_active    = r_active;
        n_row       = r_row;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        if (load) begin
            n_out_valid          = 1'b1;
            n_out_data.tile      = r_cmd.bar[3];
            n_out_data.led_index = {pix_row, ~r_cmd.bar[2:0]};
            n_out_data.red       = pix_rgb[23:16];
            n_out_data.green     = pix_rgb[15:8];
            n_out_data.blue      = pix_rgb[7:0];
            n_out_data.last      = !on_fill;
            if (on_fill) begin
                n_row = r_row + 3'd1;
            end else begin
                n_active = 1'b0;
            end
        end
        if (i_start) begin
            n_active = 1'b1;
            n_row    = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_out_data <= n_out_data;
        if (i_start) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_busy      = r_active;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // a new run is only started once the previous one has finished
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_active)
        else $error("draw started while a run is in progress");

    // every run ends with the peak write
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !n_active) |=> (r_out_valid && r_out_data.last))
        else $error("run ended without a last pixel");

    // a stalled pixel stays valid and unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled pixel changed");
`endif

endmodule

[hw/rtl/lbpm_update.sv]
// update sequencer: reads a bar's state, applies hold and decay, writes it back
module lbpm_update #(
    parameter int BARS = lbpm_pkg::BARS_DEFAULT,
    parameter int ROWS = lbpm_pkg::ROWS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lbpm_pkg::t_in_item   i_in_data,
    input  logic                 i_draw_busy,
    output logic                 o_draw_start,
    output lbpm_pkg::t_draw_cmd  o_draw_cmd
);
    import lbpm_pkg::*;

    localparam int         AW        = $clog2(BARS);
    localparam logic [4:0] BAR_LIMIT = 5'(BARS);
    localparam logic [7:0] LVL_LIMIT = 8'(ROWS);
    localparam logic [2:0] TOP_ROW   = 3'(ROWS - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } t_upd_state;

    t_upd_state       r_state, n_state;
    logic [BARS-1:0]  r_written;
    logic             r_hit_written;
    logic [AW-1:0]    r_addr;
    logic [7:0]       r_level;
    logic             accept;
    logic             in_range;
    logic             reject;
    logic             wr_en;
    logic [ENTRY_W-1:0] rd_word;
    t_bar_entry       cur;
    t_bar_entry       nxt;
    logic [2:0]       target;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign in_range   = {1'b0, i_in_data.bar} < BAR_LIMIT;

    // per-bar state store
    lbpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BARS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (nxt),
        .i_rd_en   (accept && in_range),
        .i_rd_addr (i_in_data.bar[AW-1:0]),
        .o_rd_data (rd_word)
    );

    // an entry never written reads as its reset state
    assign cur    = r_hit_written ? t_bar_entry'(rd_word) : ENTRY_RESET;
    assign reject = r_level >= LVL_LIMIT;
    assign target = cur.first ? TOP_ROW : r_level[2:0];

    // hold and decay update
    always_comb begin
        nxt          = cur;
        nxt.fill_cnt = cur.fill_cnt + 8'd1;
        nxt.peak_cnt = cur.peak_cnt + 8'd1;
        if (!reject) begin
            nxt.first = 1'b0;
            // fill level
            if (cur.fill < target) begin
                nxt.fill      = target;
                nxt.fill_hold = FILL_HOLD_LEN;
            end else if (cur.fill_hold != '0) begin
                nxt.fill_hold = cur.fill_hold - 3'd1;
            end else if (cur.fill != '0 && is_mult3(nxt.fill_cnt)) begin
                nxt.fill     = cur.fill - 3'd1;
                nxt.fill_cnt = '0;
            end
            // peak marker follows the new fill
            if (cur.peak <= nxt.fill) begin
                nxt.peak      = nxt.fill;
                nxt.peak_hold = PEAK_HOLD_LEN;
            end else if (cur.peak_hold != '0) begin
                nxt.peak_hold = cur.peak_hold - 4'd1;
            end else if (cur.peak != '0 && is_mult10(nxt.peak_cnt)) begin
                nxt.peak     = cur.peak - 3'd1;
                nxt.peak_cnt = '0;
            end
        end
    end

    // write back once the pixel writer can take the run, or at once for a rejected level
    assign wr_en        = (r_state == S_CALC) && (reject || !i_draw_busy);
    assign o_draw_start = (r_state == S_CALC) && !reject && !i_draw_busy;
    assign o_draw_cmd   = '{bar: 4'(r_addr), fill: nxt.fill, peak: nxt.peak};

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && in_range) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (wr_en) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_written <= '0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_written[r_addr] <= 1'b1;
            end
        end
    end

    // captured transaction
    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            r_addr        <= i_in_data.bar[AW-1:0];
            r_level       <= i_in_data.level;
            r_hit_written <= r_written[i_in_data.bar[AW-1:0]];
        end
    end

`ifndef SYNTHESIS
    // an accepted bar in range is worked on in the next cycle
    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_range) |=> (r_state == S_CALC))
        else $error("accepted update not processed");

    // a write back always returns the sequencer to idle
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_state == S_IDLE && r_written[$past(r_addr)]))
        else $error("write back did not complete the update");

    // a rejected level never starts a pixel run
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC && reject) |-> !o_draw_start)
        else $error("rejected level produced pixels");
`endif

endmodule

[hw/rtl/led_bar_peak_hold_meter_core.sv]
// Top level of the LED bar meter with peak hold and decay.
// An accepted update is captured by the sequencer, starts the writer, and its first pixel is registered at the output.
// Throughput: one pixel per cycle while the output is not stalled; an update with fill f gives
// f + 1 pixels, and the single pixel writer stays busy until it has loaded the last of them.
// Input stalls during the state read-modify-write, and for a level in range also while the writer is busy.
// Reset (synchronous, active low) clears valid marks so every bar reads as its reset state.
module led_bar_peak_hold_meter_core #(
    parameter int BARS = lbpm_pkg::BARS_DEFAULT,
    parameter int ROWS = lbpm_pkg::ROWS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lbpm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lbpm_pkg::t_out_item o_out_data
);
    import lbpm_pkg::*;

    logic       r_effect;
    logic [1:0] r_effect_sel;
    logic       draw_busy;
    logic       draw_start;
    t_draw_cmd  draw_cmd;

    assign o_cfg_ready = 1'b1;

    // palette select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_sel <= FX_TRAFFIC;
            r_effect     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_effect_sel <= i_cfg_data;
            r_effect     <= 1'b1;
        end
    end

    lbpm_update #(
        .BARS (BARS),
        .ROWS (ROWS)
    ) u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_draw_busy  (draw_busy),
        .o_draw_start (draw_start),
        .o_draw_cmd   (draw_cmd)
    );

    lbpm_draw u_draw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (draw_start),
        .i_cmd       (draw_cmd),
        .i_effect    (r_effect ? r_effect_sel : FX_TRAFFIC),
        .o_busy      (draw_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
